@@ rtl/clcd_pkg.sv @@
`default_nettype none
package clcd_pkg;

    localparam int LINE_CHARS_DEF = 20;
    localparam int GLYPH_BYTES    = 64;
    localparam int CHAR_W         = 8;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // command decode: exact codes and mask/match pairs
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] MASK_ENTRY   = 8'hFC;
    localparam logic [7:0] CODE_ENTRY   = 8'h04;
    localparam logic [7:0] MASK_DISPLAY = 8'hF8;
    localparam logic [7:0] CODE_DISPLAY = 8'h08;
    localparam logic [7:0] MASK_SHIFT   = 8'hF3;
    localparam logic [7:0] CODE_SHIFT   = 8'h10;
    localparam logic [7:0] MASK_FUNC    = 8'hEC;
    localparam logic [7:0] CODE_FUNC    = 8'h28;

    localparam logic [6:0] LINE2_BASE   = 7'h40;

endpackage
`default_nettype wire

@@ rtl/clcd_ram.sv @@
`default_nettype none
module clcd_ram
    import clcd_pkg::*;
#(
    parameter int WIDTH = CHAR_W,
    parameter int DEPTH = GLYPH_BYTES,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/character_lcd_controller_unit.sv @@
// Character LCD controller, bus-event level model of the controller chip.
// Input channel (s_*): one word per sample of the control port lines and
// data bus. The strobe is high only when s_enable_pin and s_enable_is_output
// are both 1; an operation runs on the word where the strobe falls.
// Result channel (m_*): exactly one word per input word, carrying whether an
// operation ran, whether the text changed, any read answer, and the mode
// flags as they stand after that word.
// Pipeline: an accepted word is presented on m_* after two register stages
// (input register, result register).
// Throughput: one word per cycle while m_ready is high, set by the single
// decode/update pass between the two registers; the glyph RAM is read ahead
// at the address the state will hold.
// Reset (aresetn low, synchronous): text store reads as spaces, glyph RAM as
// zeros (per-entry valid bits), all addresses and flags zero, both stages
// empty. No clearing pass is needed; words are taken right after reset.
// Stall: while m_ready is low the result is held and one more word can sit
// in the input register; s_ready drops only when both stages are full.
`default_nettype none
module character_lcd_controller_unit
    import clcd_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_register_select,
    input  wire logic       s_read_not_write,
    input  wire logic       s_enable_pin,
    input  wire logic       s_enable_is_output,
    input  wire logic [7:0] s_bus_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_executed,
    output logic            m_display_changed,
    output logic            m_read_valid,
    output logic [7:0]      m_read_data,
    output logic            m_display_on,
    output logic            m_cursor_on,
    output logic            m_cursor_blink,
    output logic [1:0]      m_shift_mode,
    output logic [1:0]      m_font_table,
    output logic            m_data_length,
    output logic            m_glyph_mode
);

    localparam int TEXT_LEN = 2 * LINE_CHARS;
    localparam int SLOT_W   = $clog2(TEXT_LEN);
    localparam int GA_W     = $clog2(GLYPH_BYTES);
    localparam logic [6:0] L7       = 7'(LINE_CHARS);
    localparam logic [6:0] L_LAST7  = 7'(LINE_CHARS - 1);
    localparam logic [6:0] L2_END7  = 7'(64 + LINE_CHARS);
    localparam logic [6:0] L2_LAST7 = 7'(64 + LINE_CHARS - 1);
    localparam logic [6:0] T_LAST7  = 7'(TEXT_LEN - 1);

    // input stage
    logic       in_valid_reg;
    logic       in_rs_reg, in_rd_reg, in_en_reg, in_en_out_reg;
    logic [7:0] in_data_reg;

    // controller state
    logic [TEXT_LEN-1:0][7:0]    line_reg, line_next, line_up;
    logic [GLYPH_BYTES-1:0]      glyph_valid_reg, glyph_valid_next;
    logic                        glyph_rd_valid_reg;
    logic [6:0]                  text_addr_reg, text_addr_next;
    logic [GA_W-1:0]             glyph_addr_reg, glyph_addr_next;
    logic                        step_down_reg, step_down_next;
    logic                        glyph_sel_reg, glyph_sel_next;
    logic                        strobe_prev_reg, strobe_prev_next;
    logic                        disp_reg, disp_next;
    logic                        cursor_reg, cursor_next;
    logic                        blink_reg, blink_next;
    logic [1:0]                  shift_reg, shift_next;
    logic [1:0]                  font_reg, font_next;
    logic                        width_reg, width_next;

    // result stage
    logic       m_valid_reg;
    logic       exec_reg, changed_reg, rvalid_reg;
    logic [7:0] rdata_reg;

    logic             advance, strobe, fire;
    logic             cmd_wr, data_wr, text_wr, glyph_wr, clear_cmd;
    logic             scroll1, scroll2, changed, rvalid;
    logic [6:0]       slot7, status_addr;
    logic [SLOT_W-1:0] slot;
    logic [7:0]       rdata, glyph_rd;
    logic [GA_W-1:0]  ram_rd_addr;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign strobe    = in_en_reg && in_en_out_reg;
    assign fire      = advance && strobe_prev_reg && !strobe;
    assign cmd_wr    = fire && !in_rd_reg && !in_rs_reg;
    assign data_wr   = fire && !in_rd_reg && in_rs_reg;
    assign text_wr   = data_wr && !glyph_sel_reg;
    assign glyph_wr  = data_wr && glyph_sel_reg;
    assign clear_cmd = cmd_wr && (in_data_reg == CMD_CLEAR);

    // text address -> store entry; the scroll ranges map to their line's last entry
    always_comb begin
        scroll1 = 1'b0;
        scroll2 = 1'b0;
        if (text_addr_reg < L7) begin
            slot7 = text_addr_reg;
        end else if (text_addr_reg < LINE2_BASE) begin
            slot7   = L_LAST7;
            scroll1 = 1'b1;
        end else if (text_addr_reg < L2_END7) begin
            slot7 = text_addr_reg - LINE2_BASE + L7;
        end else begin
            slot7   = T_LAST7;
            scroll2 = 1'b1;
        end
    end
    assign slot = slot7[SLOT_W-1:0];

    assign line_up = {CHAR_SPACE, line_reg[TEXT_LEN-1:1]};

    always_comb begin
        for (int i = 0; i < TEXT_LEN; i++) begin
            line_next[i] = line_reg[i];
            if (clear_cmd) begin
                line_next[i] = CHAR_SPACE;
            end else if (text_wr) begin
                if (SLOT_W'(i) == slot) begin
                    line_next[i] = in_data_reg;
                end else if (scroll1 && i < LINE_CHARS - 1) begin
                    line_next[i] = line_up[i];
                end else if (scroll2 && i >= LINE_CHARS && i < TEXT_LEN - 1) begin
                    line_next[i] = line_up[i];
                end
            end
        end
    end

    assign changed = clear_cmd || (text_wr && (line_next != line_reg));

    // state update for command and data writes
    always_comb begin
        text_addr_next   = text_addr_reg;
        glyph_addr_next  = glyph_addr_reg;
        step_down_next   = step_down_reg;
        glyph_sel_next   = glyph_sel_reg;
        strobe_prev_next = strobe_prev_reg;
        disp_next        = disp_reg;
        cursor_next      = cursor_reg;
        blink_next       = blink_reg;
        shift_next       = shift_reg;
        font_next        = font_reg;
        width_next       = width_reg;
        glyph_valid_next = glyph_valid_reg;
        if (advance) begin
            strobe_prev_next = strobe;
        end
        if (cmd_wr) begin
            priority if (in_data_reg == CMD_CLEAR) begin
                // text handled above, address kept
            end else if (in_data_reg == CMD_HOME) begin
                text_addr_next = '0;
            end else if ((in_data_reg & MASK_ENTRY) == CODE_ENTRY) begin
                step_down_next = !in_data_reg[1];
            end else if ((in_data_reg & MASK_DISPLAY) == CODE_DISPLAY) begin
                disp_next   = in_data_reg[2];
                cursor_next = in_data_reg[1];
                blink_next  = in_data_reg[0];
            end else if ((in_data_reg & MASK_SHIFT) == CODE_SHIFT) begin
                shift_next = in_data_reg[3:2];
            end else if ((in_data_reg & MASK_FUNC) == CODE_FUNC) begin
                width_next = in_data_reg[4];
                font_next  = in_data_reg[1:0];
            end else if (in_data_reg[7]) begin
                text_addr_next = in_data_reg[6:0];
                glyph_sel_next = 1'b0;
            end else if (in_data_reg[6]) begin
                glyph_addr_next = in_data_reg[GA_W-1:0];
                glyph_sel_next  = 1'b1;
            end else begin
                // unknown command
            end
        end
        if (text_wr && text_addr_reg != L7 && text_addr_reg != L2_END7) begin
            text_addr_next = step_down_reg ? text_addr_reg - 7'd1 : text_addr_reg + 7'd1;
        end
        if (glyph_wr) begin
            glyph_valid_next[glyph_addr_reg] = 1'b1;
            glyph_addr_next = step_down_reg ? glyph_addr_reg - GA_W'(1)
                                            : glyph_addr_reg + GA_W'(1);
        end
    end

    // read ahead at the address the state will hold next cycle; a glyph write
    // always moves the address, so write and read never collide
    assign ram_rd_addr = aresetn ? glyph_addr_next : '0;

    clcd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (GLYPH_BYTES)
    ) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (glyph_wr),
        .wr_addr (glyph_addr_reg),
        .wr_data (in_data_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (glyph_rd)
    );

    always_comb begin
        status_addr = text_addr_reg;
        if (status_addr > L2_LAST7) begin
            status_addr = L2_LAST7;
        end
        if (status_addr == L7) begin
            status_addr = L_LAST7;
        end
    end

    always_comb begin
        rvalid = fire && in_rd_reg;
        rdata  = '0;
        if (rvalid) begin
            unique case ({in_rs_reg, glyph_sel_reg})
                2'b11:   rdata = glyph_rd_valid_reg ? glyph_rd : '0;
                2'b10:   rdata = line_reg[slot];
                2'b01:   rdata = 8'(glyph_addr_reg);
                default: rdata = {1'b0, status_addr};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            line_reg           <= {TEXT_LEN{CHAR_SPACE}};
            glyph_valid_reg    <= '0;
            glyph_rd_valid_reg <= 1'b0;
            text_addr_reg      <= '0;
            glyph_addr_reg     <= '0;
            step_down_reg      <= 1'b0;
            glyph_sel_reg      <= 1'b0;
            strobe_prev_reg    <= 1'b0;
            disp_reg           <= 1'b0;
            cursor_reg         <= 1'b0;
            blink_reg          <= 1'b0;
            shift_reg          <= '0;
            font_reg           <= '0;
            width_reg          <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            line_reg           <= line_next;
            glyph_valid_reg    <= glyph_valid_next;
            glyph_rd_valid_reg <= glyph_valid_reg[glyph_addr_next];
            text_addr_reg      <= text_addr_next;
            glyph_addr_reg     <= glyph_addr_next;
            step_down_reg      <= step_down_next;
            glyph_sel_reg      <= glyph_sel_next;
            strobe_prev_reg    <= strobe_prev_next;
            disp_reg           <= disp_next;
            cursor_reg         <= cursor_next;
            blink_reg          <= blink_next;
            shift_reg          <= shift_next;
            font_reg           <= font_next;
            width_reg          <= width_next;
        end
        if (s_valid && s_ready) begin
            in_rs_reg     <= s_register_select;
            in_rd_reg     <= s_read_not_write;
            in_en_reg     <= s_enable_pin;
            in_en_out_reg <= s_enable_is_output;
            in_data_reg   <= s_bus_data;
        end
        if (advance) begin
            exec_reg    <= fire;
            changed_reg <= changed;
            rvalid_reg  <= rvalid;
            rdata_reg   <= rdata;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_executed        = exec_reg;
    assign m_display_changed = changed_reg;
    assign m_read_valid      = rvalid_reg;
    assign m_read_data       = rdata_reg;
    // flags track the state, which only moves when a word is passed to m_*
    assign m_display_on      = disp_reg;
    assign m_cursor_on       = cursor_reg;
    assign m_cursor_blink    = blink_reg;
    assign m_shift_mode      = shift_reg;
    assign m_font_table      = font_reg;
    assign m_data_length     = width_reg;
    assign m_glyph_mode      = glyph_sel_reg;

    a_read_needs_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_valid |-> m_executed)
        else $error("read answer without an executed operation");

    a_change_is_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_display_changed |-> m_executed && !m_read_valid)
        else $error("text change flagged on a non-write word");

    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_read_valid |-> m_read_data == 8'd0)
        else $error("read data not cleared without a read");

    a_glyph_step: assert property (@(posedge aclk) disable iff (!aresetn)
        glyph_wr |=> glyph_addr_reg != $past(glyph_addr_reg))
        else $error("glyph address did not move after a glyph write");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
    import clcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 5;
    localparam int LC          = LINE_CHARS_DEF;
    localparam int TEXT_LEN    = 2 * LC;
    localparam int L2_END      = 'h40 + LC;
    localparam int LIMIT       = 200000;
    localparam int RX_HOLD     = 300;
    localparam int MAX_PRINTS  = 40;

    localparam logic [7:0] CMD_UNKNOWN   = 8'h00;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_SET_CGRAM = 8'h40;

    typedef struct packed {
        logic       executed;
        logic       changed;
        logic       rvalid;
        logic [7:0] rdata;
        logic       disp;
        logic       cur;
        logic       blink;
        logic [1:0] shift;
        logic [1:0] font;
        logic       width;
        logic       gmode;
    } lcd_result_t;

    logic       aclk               = 1'b0;
    logic       aresetn            = 1'b0;
    logic       s_valid            = 1'b0;
    logic       s_ready;
    logic       s_register_select  = 1'b0;
    logic       s_read_not_write   = 1'b0;
    logic       s_enable_pin       = 1'b0;
    logic       s_enable_is_output = 1'b0;
    logic [7:0] s_bus_data         = 8'h00;
    logic       m_valid;
    logic       m_ready            = 1'b0;
    logic       m_executed;
    logic       m_display_changed;
    logic       m_read_valid;
    logic [7:0] m_read_data;
    logic       m_display_on;
    logic       m_cursor_on;
    logic       m_cursor_blink;
    logic [1:0] m_shift_mode;
    logic [1:0] m_font_table;
    logic       m_data_length;
    logic       m_glyph_mode;

    character_lcd_controller_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_register_select  (s_register_select),
        .s_read_not_write   (s_read_not_write),
        .s_enable_pin       (s_enable_pin),
        .s_enable_is_output (s_enable_is_output),
        .s_bus_data         (s_bus_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_executed         (m_executed),
        .m_display_changed  (m_display_changed),
        .m_read_valid       (m_read_valid),
        .m_read_data        (m_read_data),
        .m_display_on       (m_display_on),
        .m_cursor_on        (m_cursor_on),
        .m_cursor_blink     (m_cursor_blink),
        .m_shift_mode       (m_shift_mode),
        .m_font_table       (m_font_table),
        .m_data_length      (m_data_length),
        .m_glyph_mode       (m_glyph_mode)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // predicted controller state
    logic [7:0] st_text  [TEXT_LEN];
    logic [7:0] st_glyph [GLYPH_BYTES];
    logic [6:0] st_taddr;
    logic [5:0] st_gaddr;
    logic       st_down, st_gsel, st_prev;
    logic       st_disp, st_cur, st_blink;
    logic [1:0] st_shift, st_font;
    logic       st_width;

    lcd_result_t pending_results [$];

    int unsigned errors     = 0;
    int unsigned n_words    = 0;
    int unsigned n_checked  = 0;
    int unsigned n_exec     = 0;
    int unsigned n_reads    = 0;
    int unsigned n_text_wr  = 0;
    int unsigned n_scrolls  = 0;
    int unsigned n_glyph_wr = 0;
    int unsigned cycles     = 0;
    int unsigned burst_left = 0;
    int unsigned hold_req   = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned rx_count   = 0;
    int unsigned rx_style   = 0;

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch on result %0d: %s got %b want %b",
                     $realtime, n_checked, field, got, want);
    endtask

    function automatic void reset_lcd_state();
        foreach (st_text[i]) st_text[i] = CHAR_SPACE;
        foreach (st_glyph[i]) st_glyph[i] = 8'h00;
        st_taddr = '0;
        st_gaddr = '0;
        {st_down, st_gsel, st_prev, st_disp, st_cur, st_blink} = '0;
        st_shift = '0;
        st_font  = '0;
        st_width = 1'b0;
    endfunction

    function automatic void scroll_line(int base, logic [7:0] b);
        for (int i = 0; i + 1 < LC; i++)
            st_text[base + i] = st_text[base + i + 1];
        st_text[base + LC - 1] = b;
        n_scrolls++;
    endfunction

    function automatic lcd_result_t lcd_predict(logic rs, logic rw, logic en, logic dir,
                                                logic [7:0] b);
        lcd_result_t r;
        logic [7:0]  prior [TEXT_LEN];
        logic [6:0]  a;
        logic [6:0]  tstep;
        logic        strobe;
        logic        fire;
        r      = '0;
        strobe = en & dir;
        fire   = st_prev & ~strobe;
        st_prev = strobe;
        tstep  = st_down ? 7'h7F : 7'h01;
        if (fire) begin
            r.executed = 1'b1;
            n_exec++;
            if (!rw && !rs) begin
                if (b == CMD_CLEAR) begin
                    foreach (st_text[i]) st_text[i] = CHAR_SPACE;
                    r.changed = 1'b1;
                end else if (b == CMD_HOME) begin
                    st_taddr = '0;
                end else if ((b & MASK_ENTRY) == CODE_ENTRY) begin
                    st_down = ~b[1];
                end else if ((b & MASK_DISPLAY) == CODE_DISPLAY) begin
                    {st_disp, st_cur, st_blink} = b[2:0];
                end else if ((b & MASK_SHIFT) == CODE_SHIFT) begin
                    st_shift = b[3:2];
                end else if ((b & MASK_FUNC) == CODE_FUNC) begin
                    st_width = b[4];
                    st_font  = b[1:0];
                end else if (b[7]) begin
                    st_taddr = b[6:0];
                    st_gsel  = 1'b0;
                end else if (b[6]) begin
                    st_gaddr = b[5:0];
                    st_gsel  = 1'b1;
                end
            end else if (!rw) begin
                if (st_gsel) begin
                    st_glyph[st_gaddr] = b;
                    st_gaddr = st_gaddr + tstep[5:0];
                    n_glyph_wr++;
                end else begin
                    prior = st_text;
                    a = st_taddr;
                    if (a < LC)
                        st_text[a] = b;
                    else if (a < LINE2_BASE)
                        scroll_line(0, b);
                    else if (a < L2_END)
                        st_text[a - LINE2_BASE + LC] = b;
                    else
                        scroll_line(LC, b);
                    // an address just past a line's end is held there, not stepped
                    if (a != LC && a != L2_END)
                        st_taddr = st_taddr + tstep;
                    for (int i = 0; i < TEXT_LEN; i++)
                        if (prior[i] != st_text[i]) r.changed = 1'b1;
                    n_text_wr++;
                end
            end else begin
                r.rvalid = 1'b1;
                n_reads++;
                a = st_taddr;
                if (rs) begin
                    if (st_gsel)
                        r.rdata = st_glyph[st_gaddr];
                    else if (a < LC)
                        r.rdata = st_text[a];
                    else if (a < LINE2_BASE)
                        r.rdata = st_text[LC - 1];
                    else if (a < L2_END)
                        r.rdata = st_text[a - LINE2_BASE + LC];
                    else
                        r.rdata = st_text[TEXT_LEN - 1];
                end else if (st_gsel) begin
                    r.rdata = {2'b00, st_gaddr};
                end else begin
                    if (a > L2_END - 1) a = 7'(L2_END - 1);
                    if (a == LC) a = 7'(LC - 1);
                    r.rdata = {1'b0, a};
                end
            end
        end
        r.disp  = st_disp;
        r.cur   = st_cur;
        r.blink = st_blink;
        r.shift = st_shift;
        r.font  = st_font;
        r.width = st_width;
        r.gmode = st_gsel;
        return r;
    endfunction

    // one word on the input channel; valid stays up for back-to-back words
    task automatic send_word(logic rs, logic rw, logic en, logic dir, logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid            <= 1'b1;
        s_register_select  <= rs;
        s_read_not_write   <= rw;
        s_enable_pin       <= en;
        s_enable_is_output <= dir;
        s_bus_data         <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(lcd_predict(rs, rw, en, dir, b));
        n_words++;
    endtask

    // strobe high, then the falling word that carries the operation
    task automatic bus_op(logic rs, logic rw, logic [7:0] b);
        logic [1:0] low_sel;
        repeat (($urandom_range(0, 7) == 0) ? 2 : 1)
            send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1, 1'b1,
                      8'($urandom()));
        low_sel = 2'($urandom_range(0, 2));
        send_word(rs, rw, low_sel[0], low_sel[1], b);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic test_mode_commands();
        bus_op(1'b0, 1'b0, CODE_FUNC | 8'h13);
        bus_op(1'b0, 1'b0, CODE_DISPLAY | 8'h07);
        bus_op(1'b0, 1'b0, CODE_SHIFT | 8'h0C);
        bus_op(1'b0, 1'b0, CMD_UNKNOWN);
        bus_op(1'b0, 1'b0, CODE_FUNC);
    endtask

    task automatic test_text_bounds();
        // past line 2: scroll, address wraps to 0
        bus_op(1'b0, 1'b0, CMD_SET_DDRAM | 8'h7F);
        bus_op(1'b1, 1'b0, 8'hFF);
        bus_op(1'b0, 1'b1, 8'h00);
        // end of line 1, then past it: scroll with address held
        bus_op(1'b0, 1'b0, CMD_SET_DDRAM | 8'(LC - 1));
        bus_op(1'b1, 1'b0, 8'h00);
        bus_op(1'b1, 1'b0, 8'h5A);
        bus_op(1'b0, 1'b1, 8'h00);
        bus_op(1'b1, 1'b1, 8'h00);
    endtask

    task automatic test_glyph_ram();
        bus_op(1'b0, 1'b0, CMD_SET_CGRAM);
        bus_op(1'b0, 1'b0, CODE_ENTRY);
        bus_op(1'b1, 1'b0, 8'hFF);
        bus_op(1'b1, 1'b1, 8'h00);
        bus_op(1'b0, 1'b1, 8'h00);
    endtask

    task automatic test_clear_home();
        bus_op(1'b0, 1'b0, CMD_CLEAR);
        bus_op(1'b0, 1'b0, CMD_HOME);
        bus_op(1'b0, 1'b0, CODE_ENTRY | 8'h02);
    endtask

    task automatic test_random_traffic(int unsigned n);
        int unsigned target;
        int unsigned kind;
        logic [6:0]  addr;
        target = n_words + n;
        while (n_words < target) begin
            if ($urandom_range(0, 99) >= 85) begin
                send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          8'($urandom()));
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    bus_op(1'b1, 1'b0, 8'($urandom()));
                end else if (kind < 40) begin
                    bus_op(1'b1, 1'b1, 8'($urandom()));
                end else if (kind < 48) begin
                    bus_op(1'b0, 1'b1, 8'($urandom()));
                end else if (kind < 60) begin
                    case ($urandom_range(0, 11))
                        0:       addr = 7'd0;
                        1:       addr = 7'(LC - 1);
                        2:       addr = 7'(LC);
                        3:       addr = 7'(LC + 1);
                        4:       addr = 7'h3F;
                        5:       addr = LINE2_BASE;
                        6:       addr = 7'(L2_END - 1);
                        7:       addr = 7'(L2_END);
                        8:       addr = 7'h7F;
                        default: addr = 7'($urandom());
                    endcase
                    bus_op(1'b0, 1'b0, CMD_SET_DDRAM | {1'b0, addr});
                end else if (kind < 67) begin
                    bus_op(1'b0, 1'b0, CMD_SET_CGRAM | 8'($urandom_range(0, 63)));
                end else if (kind < 72) begin
                    bus_op(1'b0, 1'b0, CODE_ENTRY | 8'($urandom_range(0, 3)));
                end else if (kind < 77) begin
                    bus_op(1'b0, 1'b0, CODE_DISPLAY | 8'($urandom_range(0, 7)));
                end else if (kind < 81) begin
                    bus_op(1'b0, 1'b0, CODE_SHIFT | 8'($urandom_range(0, 3) << 2));
                end else if (kind < 85) begin
                    bus_op(1'b0, 1'b0, CODE_FUNC | 8'($urandom_range(0, 1) << 4)
                                                 | 8'($urandom_range(0, 3)));
                end else if (kind < 88) begin
                    bus_op(1'b0, 1'b0, CMD_CLEAR);
                end else if (kind < 90) begin
                    bus_op(1'b0, 1'b0, CMD_HOME);
                end else begin
                    bus_op(1'b0, 1'b0, 8'($urandom()));
                end
            end
        end
    endtask

    // receiver holds off while words keep coming, so both stages fill
    task automatic test_backpressure();
        hold_req++;
        test_random_traffic(40);
        wait_idle();
    endtask

    // result channel: check each word, then pick the next ready level
    always @(posedge aclk) begin
        lcd_result_t got;
        lcd_result_t want;
        if (m_valid && m_ready) begin
            got = {m_executed, m_display_changed, m_read_valid, m_read_data, m_display_on,
                   m_cursor_on, m_cursor_blink, m_shift_mode, m_font_table, m_data_length,
                   m_glyph_mode};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", got.rdata, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (got.executed !== want.executed)
                    report_mismatch("executed", 8'(got.executed), 8'(want.executed));
                if (got.changed !== want.changed)
                    report_mismatch("display_changed", 8'(got.changed), 8'(want.changed));
                if (got.rvalid !== want.rvalid)
                    report_mismatch("read_valid", 8'(got.rvalid), 8'(want.rvalid));
                if (got.rdata !== want.rdata)
                    report_mismatch("read_data", got.rdata, want.rdata);
                if (got.disp !== want.disp)
                    report_mismatch("display_on", 8'(got.disp), 8'(want.disp));
                if (got.cur !== want.cur)
                    report_mismatch("cursor_on", 8'(got.cur), 8'(want.cur));
                if (got.blink !== want.blink)
                    report_mismatch("cursor_blink", 8'(got.blink), 8'(want.blink));
                if (got.shift !== want.shift)
                    report_mismatch("shift_mode", 8'(got.shift), 8'(want.shift));
                if (got.font !== want.font)
                    report_mismatch("font_table", 8'(got.font), 8'(want.font));
                if (got.width !== want.width)
                    report_mismatch("data_length", 8'(got.width), 8'(want.width));
                if (got.gmode !== want.gmode)
                    report_mismatch("glyph_mode", 8'(got.gmode), 8'(want.gmode));
            end
            n_checked++;
        end
        rx_count++;
        if (rx_count % 64 == 0)
            rx_style = $urandom_range(0, 3);
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = RX_HOLD;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= (rx_count % 8 < 5);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycles, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        reset_lcd_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_mode_commands();
        test_text_bounds();
        test_glyph_ram();
        test_clear_home();
        wait_idle();
        test_random_traffic(750);
        test_backpressure();
        test_random_traffic(750);
        wait_idle();
        repeat (8) @(posedge aclk);

        if (pending_results.size() != 0)
            report_mismatch("words left unanswered", 8'(pending_results.size()), 8'h00);
        $display("covered %0d words, %0d operations: %0d reads, %0d text writes",
                 n_words, n_exec, n_reads, n_text_wr);
        $display("  (%0d line scrolls), %0d glyph writes; %0d results checked, %0d errors",
                 n_scrolls, n_glyph_wr, n_checked, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
